// ----- design/rtc_pkg.sv -----
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared constants for the run-length text codec.
// ----------------------------------------------------------------------------
package rtc_pkg;

    localparam int DEF_COUNT_DIGITS = 5;
    localparam int DEF_QUEUE_DEPTH  = 2;

    localparam int CHAR_W = 8;
    localparam int REP_W  = 17;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

endpackage

// ----- design/rtc_front.sv -----
// ----------------------------------------------------------------------------
// rtc_front
// Accepts characters, tracks the run or the decimal count, and issues one
// job word for each character that causes output.
// ----------------------------------------------------------------------------
module rtc_front #(
    parameter int COUNT_DIGITS = rtc_pkg::DEF_COUNT_DIGITS,
    parameter int BCD_W        = 4 * COUNT_DIGITS,
    parameter int CNT_W        = $clog2(10 ** COUNT_DIGITS)
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_decompress_mode,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [rtc_pkg::CHAR_W-1:0] s_in_char,
    input  logic                      s_end_of_string,

    output logic                      job_valid,
    input  logic                      job_ready,
    output logic [BCD_W-1:0]          job_bcd,
    output logic [rtc_pkg::CHAR_W-1:0] job_a_char,
    output logic [CNT_W-1:0]          job_a_rep,
    output logic                      job_b_valid,
    output logic [rtc_pkg::CHAR_W-1:0] job_b_char,
    output logic                      job_eos
);

    localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(10 ** COUNT_DIGITS - 1);
    localparam logic [BCD_W-1:0] BCD_ONE     = BCD_W'(1);
    localparam int               PROD_W      = CNT_W + 4;

    logic                       mode_reg;
    logic [rtc_pkg::CHAR_W-1:0] run_char_reg, run_char_next;
    logic [BCD_W-1:0]           run_bcd_reg, run_bcd_next;
    logic                       run_open_reg, run_open_next;
    logic [CNT_W-1:0]           dec_cnt_reg, dec_cnt_next;
    logic                       digits_seen_reg, digits_seen_next;

    logic                       accept;
    logic                       same_char;
    logic                       is_digit;
    logic [BCD_W-1:0]           cur_bcd;
    logic [PROD_W-1:0]          prod;

    function automatic logic [BCD_W-1:0] bcd_increment(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] r;
        logic             carry;
        r     = v;
        carry = 1'b1;
        for (int i = 0; i < COUNT_DIGITS; i++) begin
            if (carry) begin
                if (v[4*i +: 4] < 4'd9) begin
                    r[4*i +: 4] = v[4*i +: 4] + 4'd1;
                    carry       = 1'b0;
                end else begin
                    r[4*i +: 4] = 4'd0;
                end
            end
        end
        return r;
    endfunction

    function automatic logic bcd_is_full(input logic [BCD_W-1:0] v);
        logic f;
        f = 1'b1;
        for (int i = 0; i < COUNT_DIGITS; i++) begin
            if (v[4*i +: 4] != 4'd9) begin
                f = 1'b0;
            end
        end
        return f;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_ready   = job_ready;
    assign accept    = s_valid && s_ready;
    assign job_eos   = s_end_of_string;

    assign same_char = run_open_reg && (s_in_char == run_char_reg);
    assign is_digit  = s_in_char inside {[rtc_pkg::CHAR_ZERO : rtc_pkg::CHAR_NINE]};
    assign prod      = PROD_W'({dec_cnt_reg, 3'b000}) + PROD_W'({dec_cnt_reg, 1'b0})
                     + PROD_W'(s_in_char[3:0]);

    always_comb begin
        run_char_next    = run_char_reg;
        run_bcd_next     = run_bcd_reg;
        run_open_next    = run_open_reg;
        dec_cnt_next     = dec_cnt_reg;
        digits_seen_next = digits_seen_reg;
        job_valid        = 1'b0;
        job_bcd          = '0;
        job_a_char       = s_in_char;
        job_a_rep        = CNT_W'(1);
        job_b_valid      = 1'b0;
        job_b_char       = s_in_char;
        cur_bcd          = BCD_ONE;
        if (accept) begin
            if (!mode_reg) begin
                if (same_char) begin
                    cur_bcd = bcd_increment(run_bcd_reg);
                end else if (run_open_reg) begin
                    job_valid  = 1'b1;
                    job_bcd    = run_bcd_reg;
                    job_a_char = run_char_reg;
                end
                run_char_next = s_in_char;
                if (bcd_is_full(cur_bcd) || s_end_of_string) begin
                    if (job_valid) begin
                        job_b_valid = 1'b1;
                    end else begin
                        job_valid = 1'b1;
                        job_bcd   = cur_bcd;
                    end
                    run_open_next = 1'b0;
                    run_bcd_next  = '0;
                end else begin
                    run_open_next = 1'b1;
                    run_bcd_next  = cur_bcd;
                end
            end else begin
                if (is_digit) begin
                    if (prod > PROD_W'(COUNT_LIMIT)) begin
                        dec_cnt_next = COUNT_LIMIT;
                    end else begin
                        dec_cnt_next = prod[CNT_W-1:0];
                    end
                    digits_seen_next = 1'b1;
                end else begin
                    if (!digits_seen_reg) begin
                        job_valid = 1'b1;
                    end else if (dec_cnt_reg != '0) begin
                        job_valid = 1'b1;
                        job_a_rep = dec_cnt_reg;
                    end
                    dec_cnt_next     = '0;
                    digits_seen_next = 1'b0;
                end
                if (s_end_of_string) begin
                    dec_cnt_next     = '0;
                    digits_seen_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= 1'b0;
            run_char_reg    <= '0;
            run_bcd_reg     <= '0;
            run_open_reg    <= 1'b0;
            dec_cnt_reg     <= '0;
            digits_seen_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_decompress_mode;
            end
            run_char_reg    <= run_char_next;
            run_bcd_reg     <= run_bcd_next;
            run_open_reg    <= run_open_next;
            dec_cnt_reg     <= dec_cnt_next;
            digits_seen_reg <= digits_seen_next;
        end
    end

endmodule

// ----- design/rtc_queue.sv -----
// ----------------------------------------------------------------------------
// rtc_queue
// Short register queue that carries job words from the front to the back.
// ----------------------------------------------------------------------------
module rtc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rtc_pkg::DEF_QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             push, pop;

    assign wr_ready = (fill_reg != CNT_W'(DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ----- design/rtc_back.sv -----
// ----------------------------------------------------------------------------
// rtc_back
// Expands each job word into result words: count digits, run character and
// an optional trailing single character, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
module rtc_back #(
    parameter int COUNT_DIGITS = rtc_pkg::DEF_COUNT_DIGITS,
    parameter int BCD_W        = 4 * COUNT_DIGITS,
    parameter int CNT_W        = $clog2(10 ** COUNT_DIGITS)
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       job_valid,
    output logic                       job_ready,
    input  logic [BCD_W-1:0]           job_bcd,
    input  logic [rtc_pkg::CHAR_W-1:0] job_a_char,
    input  logic [CNT_W-1:0]           job_a_rep,
    input  logic                       job_b_valid,
    input  logic [rtc_pkg::CHAR_W-1:0] job_b_char,
    input  logic                       job_eos,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [rtc_pkg::CHAR_W-1:0] m_out_char,
    output logic [rtc_pkg::REP_W-1:0]  m_repeat_count,
    output logic                       m_last_of_item,
    output logic                       m_string_done
);

    localparam int DIG_W = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;

    localparam logic [1:0] PH_DIGIT = 2'd0;
    localparam logic [1:0] PH_ACHAR = 2'd1;
    localparam logic [1:0] PH_BCHAR = 2'd2;

    logic                       busy_reg;
    logic [1:0]                 phase_reg;
    logic [DIG_W-1:0]           dig_reg;
    logic [BCD_W-1:0]           bcd_reg;
    logic [rtc_pkg::CHAR_W-1:0] a_char_reg, b_char_reg;
    logic [CNT_W-1:0]           a_rep_reg;
    logic                       b_valid_reg, eos_reg;

    logic                       m_valid_reg;
    logic [rtc_pkg::CHAR_W-1:0] out_char_reg, out_char_next;
    logic [rtc_pkg::REP_W-1:0]  rep_reg, rep_next;
    logic                       last_reg, last_next;
    logic                       done_flag_reg;

    logic                       adv, load;
    logic [1:0]                 phase_next;
    logic [DIG_W-1:0]           top_dig;

    function automatic logic [DIG_W-1:0] top_digit(input logic [BCD_W-1:0] v);
        logic [DIG_W-1:0] t;
        t = '0;
        for (int i = 0; i < COUNT_DIGITS; i++) begin
            if (v[4*i +: 4] != 4'd0) begin
                t = DIG_W'(i);
            end
        end
        return t;
    endfunction

    assign top_dig   = top_digit(job_bcd);
    assign adv       = busy_reg && (!m_valid_reg || m_ready);
    assign load      = job_valid && (!busy_reg || (adv && last_next));
    assign job_ready = !busy_reg || (adv && last_next);

    always_comb begin
        out_char_next = a_char_reg;
        rep_next      = rtc_pkg::REP_W'(1);
        last_next     = 1'b0;
        phase_next    = phase_reg;
        case (phase_reg)
            PH_DIGIT: begin
                out_char_next = rtc_pkg::CHAR_ZERO
                              + {4'd0, bcd_reg[4*dig_reg +: 4]};
                if (dig_reg == '0) begin
                    phase_next = PH_ACHAR;
                end
            end
            PH_ACHAR: begin
                rep_next = rtc_pkg::REP_W'(a_rep_reg);
                if (b_valid_reg) begin
                    phase_next = PH_BCHAR;
                end else begin
                    last_next = 1'b1;
                end
            end
            PH_BCHAR: begin
                out_char_next = b_char_reg;
                last_next     = 1'b1;
            end
            default: begin
                last_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bcd_reg     <= job_bcd;
            a_char_reg  <= job_a_char;
            a_rep_reg   <= job_a_rep;
            b_valid_reg <= job_b_valid;
            b_char_reg  <= job_b_char;
            eos_reg     <= job_eos;
            dig_reg     <= top_dig;
        end else if (adv && phase_reg == PH_DIGIT) begin
            dig_reg <= dig_reg - DIG_W'(1);
        end
        if (adv) begin
            out_char_reg  <= out_char_next;
            rep_reg       <= rep_next;
            last_reg      <= last_next;
            done_flag_reg <= last_next && eos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            phase_reg   <= PH_ACHAR;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                busy_reg  <= 1'b1;
                phase_reg <= (job_bcd > BCD_W'(1)) ? PH_DIGIT : PH_ACHAR;
            end else if (adv) begin
                phase_reg <= phase_next;
                if (last_next) begin
                    busy_reg <= 1'b0;
                end
            end
            if (adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_char     = out_char_reg;
    assign m_repeat_count = rep_reg;
    assign m_last_of_item = last_reg;
    assign m_string_done  = done_flag_reg;

endmodule

// ----- design/rle_text_codec.sv -----
// ----------------------------------------------------------------------------
// rle_text_codec
// Run-length text codec with decimal count prefix, compress or expand mode.
// ----------------------------------------------------------------------------
//  Channel  Dir  Word
//  cfg      in   cfg_decompress_mode
//  s        in   s_in_char, s_end_of_string
//  m        out  m_out_char, m_repeat_count, m_last_of_item, m_string_done
//
// A character is taken in every cycle while the job queue has room; the
// front updates its run or count state in that same cycle.
// The back sends one result word per cycle while the sink takes them: the
// count digits if above one, then the run character and a trailing one.
// Reset clears all run and count state and the queue; no clearing pass.
// A stalled output holds its word and the queue keeps taking characters
// until it fills.
// ----------------------------------------------------------------------------
module rle_text_codec #(
    parameter int COUNT_DIGITS = rtc_pkg::DEF_COUNT_DIGITS,
    parameter int QUEUE_DEPTH  = rtc_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_decompress_mode,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [rtc_pkg::CHAR_W-1:0] s_in_char,
    input  logic                       s_end_of_string,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [rtc_pkg::CHAR_W-1:0] m_out_char,
    output logic [rtc_pkg::REP_W-1:0]  m_repeat_count,
    output logic                       m_last_of_item,
    output logic                       m_string_done
);

    localparam int BCD_W = 4 * COUNT_DIGITS;
    localparam int CNT_W = $clog2(10 ** COUNT_DIGITS);
    localparam int JOB_W = BCD_W + CNT_W + 2 * rtc_pkg::CHAR_W + 2;

    logic                       fj_valid, fj_ready;
    logic [BCD_W-1:0]           fj_bcd;
    logic [rtc_pkg::CHAR_W-1:0] fj_a_char, fj_b_char;
    logic [CNT_W-1:0]           fj_a_rep;
    logic                       fj_b_valid, fj_eos;

    logic                       bj_valid, bj_ready;
    logic [BCD_W-1:0]           bj_bcd;
    logic [rtc_pkg::CHAR_W-1:0] bj_a_char, bj_b_char;
    logic [CNT_W-1:0]           bj_a_rep;
    logic                       bj_b_valid, bj_eos;

    logic [JOB_W-1:0]           wr_word, rd_word;

    rtc_front #(
        .COUNT_DIGITS(COUNT_DIGITS),
        .BCD_W(BCD_W),
        .CNT_W(CNT_W)
    ) u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_decompress_mode(cfg_decompress_mode),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_in_char(s_in_char),
        .s_end_of_string(s_end_of_string),
        .job_valid(fj_valid),
        .job_ready(fj_ready),
        .job_bcd(fj_bcd),
        .job_a_char(fj_a_char),
        .job_a_rep(fj_a_rep),
        .job_b_valid(fj_b_valid),
        .job_b_char(fj_b_char),
        .job_eos(fj_eos)
    );

    assign wr_word = {fj_bcd, fj_a_char, fj_a_rep, fj_b_valid, fj_b_char, fj_eos};

    rtc_queue #(
        .WIDTH(JOB_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk(aclk),
        .aresetn(aresetn),
        .wr_valid(fj_valid),
        .wr_ready(fj_ready),
        .wr_data(wr_word),
        .rd_valid(bj_valid),
        .rd_ready(bj_ready),
        .rd_data(rd_word)
    );

    assign {bj_bcd, bj_a_char, bj_a_rep, bj_b_valid, bj_b_char, bj_eos} = rd_word;

    rtc_back #(
        .COUNT_DIGITS(COUNT_DIGITS),
        .BCD_W(BCD_W),
        .CNT_W(CNT_W)
    ) u_back (
        .aclk(aclk),
        .aresetn(aresetn),
        .job_valid(bj_valid),
        .job_ready(bj_ready),
        .job_bcd(bj_bcd),
        .job_a_char(bj_a_char),
        .job_a_rep(bj_a_rep),
        .job_b_valid(bj_b_valid),
        .job_b_char(bj_b_char),
        .job_eos(bj_eos),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_out_char(m_out_char),
        .m_repeat_count(m_repeat_count),
        .m_last_of_item(m_last_of_item),
        .m_string_done(m_string_done)
    );

endmodule

// ----- design/rtc_checker.sv -----
// ----------------------------------------------------------------------------
// rtc_checker
// Port-level checks for the run-length text codec, bound to the top level.
// ----------------------------------------------------------------------------
module rtc_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [rtc_pkg::CHAR_W-1:0] m_out_char,
    input logic [rtc_pkg::REP_W-1:0]  m_repeat_count,
    input logic                       m_last_of_item,
    input logic                       m_string_done
);

    // A word held back by the sink keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_char)
            && $stable(m_repeat_count) && $stable(m_last_of_item)
            && $stable(m_string_done))
        else $error("stalled result word changed");

    // The end of a string always closes the words of its character.
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_string_done |-> m_last_of_item)
        else $error("string_done without last_of_item");

    // Only an expanded text character carries a repeat count other than one.
    a_rep_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_repeat_count != rtc_pkg::REP_W'(1)
            |-> (m_out_char < rtc_pkg::CHAR_ZERO || m_out_char > rtc_pkg::CHAR_NINE))
        else $error("digit word with repeat count other than one");

    // No result word is presented in the cycle after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid right after reset");

endmodule

bind rle_text_codec rtc_checker u_rtc_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_out_char(m_out_char),
    .m_repeat_count(m_repeat_count),
    .m_last_of_item(m_last_of_item),
    .m_string_done(m_string_done)
);
